// ===== sv/tegotae_phase_oscillator_top_defines.svh =====
// Assertion macros for the Tegotae phase oscillator.
// Included by the top level; expands to nothing when SYNTH is defined.
`ifndef TEGOTAE_PHASE_OSCILLATOR_TOP_DEFINES_SVH
`define TEGOTAE_PHASE_OSCILLATOR_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clock, disabled during reset.
`define TPO_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("phase oscillator: same-cycle check failed");
// Next-cycle implication, sampled on clock, disabled during reset.
`define TPO_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("phase oscillator: next-cycle check failed");
`else
`define TPO_ASSERT_IMP(name, ante, cons)
`define TPO_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== sv/tpo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the Tegotae phase oscillator.
// No dependencies; every module in the project imports this package.
package tpo_pkg;

   // Default sizes of the phase accumulator and the sine table.
   localparam int TPO_PHASE_BITS      = 16;
   localparam int TPO_SINE_TABLE_BITS = 10;

   // Bits of the multiplier operand consumed per cycle.
   localparam int MUL_DIGIT = 4;

   // Field and datapath widths.
   localparam int CSR_ADDR_W = 5;
   localparam int AMP_W      = 16;
   localparam int TRIG_W     = 15;
   localparam int FORCE_W    = 24;
   localparam int SUM_W      = 32;
   localparam int SUM_MAG_W  = 31;
   localparam int GCOS_W     = AMP_W + TRIG_W;
   localparam int FEED_W     = GCOS_W + SUM_MAG_W;
   localparam int Q15_HALF   = 16384;

   // Fixed-point constants used to build the sine table.
   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   // Input item modes.
   typedef enum logic [1:0] {
      MODE_CLEAR_ADD = 2'd0,
      MODE_ADD       = 2'd1,
      MODE_TICK      = 2'd2
   } mode_type;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      CSR_PHASE_STEP       = 3'd0,
      CSR_FEEDBACK_GAIN    = 3'd1,
      CSR_SWING_AMPLITUDE  = 3'd2,
      CSR_STANCE_AMPLITUDE = 3'd3,
      CSR_FORE_AMPLITUDE   = 3'd4,
      CSR_START_PHASE      = 3'd5
   } csr_index_type;

   // Sequencer states for one tick.
   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_LOOKUP   = 3'd1,
      ST_MUL_TRIG = 3'd2,
      ST_MUL_FEED = 3'd3,
      ST_FINISH   = 3'd4
   } tpo_state_type;

   // Sine and cosine as magnitude plus sign.
   typedef struct packed {
      logic [TRIG_W-1:0] cos_mag;
      logic              cos_neg;
      logic [TRIG_W-1:0] sin_mag;
      logic              sin_neg;
   } trig_type;

   // Status of a digit-serial multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mul_stat_type;

   // Quarter-wave sine magnitude in Q15 for table point r out of 2^stb per turn.
   // Odd polynomial to x^11 evaluated in Q30, rounded half up and saturated.
   function automatic logic [TRIG_W-1:0] quarter_sine(input logic [31:0] r,
                                                      input logic [31:0] stb);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] m;
      begin
         x  = (64'(r) * TWO_PI_Q30) >> stb;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
         t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
         s  = (x * t) >> 30;
         m  = (s + 64'd16384) >> 15;
         if (m > 64'd32767) begin
            m = 64'd32767;
         end
         return m[TRIG_W-1:0];
      end
   endfunction

endpackage

// ===== sv/tpo_trig.sv =====
`timescale 1ns / 1ps
// Sine and cosine lookup from a folded quarter-wave constant table.
// Depends on tpo_pkg for trig_type and the table builder function.
module tpo_trig
   import tpo_pkg::*;
#(
   parameter int SINE_TABLE_BITS = TPO_SINE_TABLE_BITS
) (
   input  logic [SINE_TABLE_BITS-1:0] table_index,
   output trig_type                   trig
);

   localparam int QUARTER = 2 ** (SINE_TABLE_BITS - 2);
   localparam int R_W     = SINE_TABLE_BITS - 1;

   logic [TRIG_W-1:0]          qtab [QUARTER+1];
   logic [SINE_TABLE_BITS-1:0] cos_index;
   logic [R_W-1:0]             sin_r;
   logic [R_W-1:0]             cos_r;

   // The quarter wave, including the peak point, built at elaboration.
   for (genvar g = 0; g <= QUARTER; g++) begin : g_qtab
      localparam logic [TRIG_W-1:0] ENTRY =
         quarter_sine(32'(g), 32'(SINE_TABLE_BITS));
      assign qtab[g] = ENTRY;
   end

   // Cosine is sine a quarter turn ahead.
   assign cos_index = table_index + SINE_TABLE_BITS'(QUARTER);

   // Fold each index into the first quarter; odd quarters run backwards.
   always_comb begin
      sin_r = {1'b0, table_index[SINE_TABLE_BITS-3:0]};
      if (table_index[SINE_TABLE_BITS-2]) begin
         sin_r = R_W'(QUARTER) - {1'b0, table_index[SINE_TABLE_BITS-3:0]};
      end
      cos_r = {1'b0, cos_index[SINE_TABLE_BITS-3:0]};
      if (cos_index[SINE_TABLE_BITS-2]) begin
         cos_r = R_W'(QUARTER) - {1'b0, cos_index[SINE_TABLE_BITS-3:0]};
      end
   end

   // The second half turn is negative.
   always_comb begin
      trig.sin_mag = qtab[sin_r];
      trig.sin_neg = table_index[SINE_TABLE_BITS-1];
      trig.cos_mag = qtab[cos_r];
      trig.cos_neg = cos_index[SINE_TABLE_BITS-1];
   end

endmodule

// ===== sv/tpo_digit_mul.sv =====
`timescale 1ns / 1ps
// Unsigned digit-serial multiplier: parallel multiplicand, multiplier
// consumed MUL_DIGIT bits per cycle. Depends on tpo_pkg.
module tpo_digit_mul
   import tpo_pkg::*;
#(
   parameter int A_W = AMP_W,
   parameter int B_W = TRIG_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     mul_a,
   input  logic [B_W-1:0]     mul_b,
   output logic [A_W+B_W-1:0] product,
   output mul_stat_type       stat
);

   localparam int N_DIG  = (B_W + MUL_DIGIT - 1) / MUL_DIGIT;
   localparam int BP_W   = N_DIG * MUL_DIGIT;
   localparam int PART_W = A_W + MUL_DIGIT;
   localparam int CNT_W  = (N_DIG > 1) ? $clog2(N_DIG) : 1;
   localparam int FULL_W = A_W + BP_W;

   logic [A_W-1:0]            a_ff, a_in;
   logic [BP_W-1:0]           b_ff, b_in;
   logic [A_W-1:0]            acc_ff, acc_in;
   logic [BP_W-1:0]           low_ff, low_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [PART_W-1:0]         part;
   logic [PART_W-1:0]         sum;
   logic [BP_W+MUL_DIGIT-1:0] low_cat;
   logic [FULL_W-1:0]         full;
   logic                      last;

   // One digit step: add multiplicand times digit, shift one digit out.
   always_comb begin
      part    = PART_W'(a_ff) * PART_W'(b_ff[MUL_DIGIT-1:0]);
      sum     = PART_W'(acc_ff) + part;
      low_cat = {sum[MUL_DIGIT-1:0], low_ff};
      last    = cnt_ff == CNT_W'(N_DIG - 1);
   end

   // Load on start, then step once per cycle until the last digit.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = mul_a;
         b_in    = BP_W'(mul_b);
         acc_in  = '0;
         low_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[PART_W-1:MUL_DIGIT];
         low_in = low_cat[BP_W+MUL_DIGIT-1:MUL_DIGIT];
         b_in   = b_ff >> MUL_DIGIT;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath shift registers.
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      low_ff <= low_in;
   end

   assign full        = {acc_ff, low_ff};
   assign product     = full[A_W+B_W-1:0];
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;

endmodule

// ===== sv/tegotae_phase_oscillator_top.sv =====
`timescale 1ns / 1ps
// Tegotae leg oscillator. A force beat (mode 0 or 1) updates the saturating
// ground-force sum, so force beats stream at one per cycle while the block is
// idle. A tick beat runs these steps at the default widths: accept, the
// sine/cosine table lookup, then the 4-bit digit-serial multipliers run
// ceil(15/4) = 4 steps for the trig products and signal done, ceil(31/4) = 8
// steps for the force feedback product and signal done, and a finishing state
// rounds, saturates and loads the result register. The finishing state waits
// while a previous result is still stalled on rsp_stall. Registers sit at byte
// address 4*i; writing start_phase also loads the phase. Depends on tpo_pkg,
// tpo_trig, tpo_digit_mul and the assertion macro header.
`include "tegotae_phase_oscillator_top_defines.svh"
module tegotae_phase_oscillator_top
   import tpo_pkg::*;
#(
   parameter int PHASE_BITS      = TPO_PHASE_BITS,
   parameter int SINE_TABLE_BITS = TPO_SINE_TABLE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic signed [23:0]    req_reaction_force,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_fore_target,
   output logic signed [15:0]    rsp_height_target,
   output logic [15:0]           rsp_phase_now,
   output logic signed [15:0]    rsp_phase_rate,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int RATE_SHIFT = 40 - PHASE_BITS;

   // Absolute value of a 16-bit signed amplitude, as unsigned.
   function automatic logic [AMP_W-1:0] abs16(input logic [AMP_W-1:0] v);
      begin
         return v[AMP_W-1] ? (AMP_W'(0) - v) : v;
      end
   endfunction

   // Product over 2^15, rounded half away from zero, sign applied.
   function automatic logic [15:0] round_q15(input logic [GCOS_W-1:0] prod,
                                             input logic neg);
      logic [GCOS_W-1:0] rnd;
      logic [15:0]       mag;
      begin
         rnd = prod + GCOS_W'(Q15_HALF);
         mag = rnd[GCOS_W-1:15];
         return neg ? (16'd0 - mag) : mag;
      end
   endfunction

   // Configuration registers.
   logic [15:0] phase_step_ff, phase_step_in;
   logic [15:0] feedback_gain_ff, feedback_gain_in;
   logic [15:0] swing_amplitude_ff, swing_amplitude_in;
   logic [15:0] stance_amplitude_ff, stance_amplitude_in;
   logic [15:0] fore_amplitude_ff, fore_amplitude_in;
   logic [15:0] start_phase_ff, start_phase_in;

   // Oscillator state and sequencer.
   tpo_state_type            state_ff, state_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [SUM_W-1:0]         force_sum_ff, force_sum_in;

   // Result register.
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [15:0]              rsp_fore_ff, rsp_fore_in;
   logic [15:0]              rsp_height_ff, rsp_height_in;
   logic [15:0]              rsp_phase_ff, rsp_phase_in;
   logic [15:0]              rsp_rate_ff, rsp_rate_in;

   // Handshake and control.
   logic                     cfg_wr;
   logic [2:0]               cfg_idx;
   logic                     req_take;
   logic                     out_free;
   logic                     trig_start;
   logic                     feed_start;
   logic                     out_load;

   // Datapath.
   logic [PHASE_BITS+13:0]      phase_idx_wide;
   logic [SINE_TABLE_BITS-1:0]  table_index;
   trig_type                    trig;
   logic [AMP_W-1:0]            height_amp;
   logic [GCOS_W-1:0]           fore_prod;
   logic [GCOS_W-1:0]           height_prod;
   logic [GCOS_W-1:0]           gcos_prod;
   logic [FEED_W-1:0]           feed_prod;
   mul_stat_type                fore_stat;
   mul_stat_type                height_stat;
   mul_stat_type                gcos_stat;
   mul_stat_type                feed_stat;
   logic [SUM_W:0]              force_add;
   logic [SUM_W-1:0]            force_base;
   logic [FEED_W:0]             feed_rnd;
   logic                        term_big;
   logic [17:0]                 rate_sum;
   logic [15:0]                 rate_val;
   logic signed [39:0]          rate_aligned;
   logic [39:0]                 start_wide;
   logic [PHASE_BITS+15:0]      phase_out_wide;

   assign cfg_wr   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx  = csr_paddr[CSR_ADDR_W-1:2];
   assign req_take = req_valid & ~req_stall;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Register write decode; indexes past the list are ignored.
   always_comb begin
      phase_step_in       = phase_step_ff;
      feedback_gain_in    = feedback_gain_ff;
      swing_amplitude_in  = swing_amplitude_ff;
      stance_amplitude_in = stance_amplitude_ff;
      fore_amplitude_in   = fore_amplitude_ff;
      start_phase_in      = start_phase_ff;
      if (cfg_wr) begin
         unique case (csr_index_type'(cfg_idx))
            CSR_PHASE_STEP:       phase_step_in       = csr_pwdata[15:0];
            CSR_FEEDBACK_GAIN:    feedback_gain_in    = csr_pwdata[15:0];
            CSR_SWING_AMPLITUDE:  swing_amplitude_in  = csr_pwdata[15:0];
            CSR_STANCE_AMPLITUDE: stance_amplitude_in = csr_pwdata[15:0];
            CSR_FORE_AMPLITUDE:   fore_amplitude_in   = csr_pwdata[15:0];
            CSR_START_PHASE:      start_phase_in      = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (csr_index_type'(cfg_idx))
         CSR_PHASE_STEP:       csr_prdata = {16'd0, phase_step_ff};
         CSR_FEEDBACK_GAIN:    csr_prdata = {16'd0, feedback_gain_ff};
         CSR_SWING_AMPLITUDE:  csr_prdata = {16'd0, swing_amplitude_ff};
         CSR_STANCE_AMPLITUDE: csr_prdata = {16'd0, stance_amplitude_ff};
         CSR_FORE_AMPLITUDE:   csr_prdata = {16'd0, fore_amplitude_ff};
         CSR_START_PHASE:      csr_prdata = {16'd0, start_phase_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Table index is the top bits of the phase; trig lookup is combinational.
   assign phase_idx_wide = {phase_ff, 14'd0};
   assign table_index    = phase_idx_wide[PHASE_BITS+13 -: SINE_TABLE_BITS];

   tpo_trig #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_trig (
      .table_index (table_index),
      .trig        (trig)
   );

   // Height uses the swing amplitude in the first half turn.
   assign height_amp = phase_ff[PHASE_BITS-1] ? stance_amplitude_ff : swing_amplitude_ff;

   // Three trig products run side by side.
   tpo_digit_mul #(.A_W(AMP_W), .B_W(TRIG_W)) u_mul_fore (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .mul_a   (abs16(fore_amplitude_ff)),
      .mul_b   (trig.cos_mag),
      .product (fore_prod),
      .stat    (fore_stat)
   );

   tpo_digit_mul #(.A_W(AMP_W), .B_W(TRIG_W)) u_mul_height (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .mul_a   (abs16(height_amp)),
      .mul_b   (trig.sin_mag),
      .product (height_prod),
      .stat    (height_stat)
   );

   tpo_digit_mul #(.A_W(AMP_W), .B_W(TRIG_W)) u_mul_gcos (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .mul_a   (feedback_gain_ff),
      .mul_b   (trig.cos_mag),
      .product (gcos_prod),
      .stat    (gcos_stat)
   );

   // Gain times |cos| times the clamped force sum.
   tpo_digit_mul #(.A_W(GCOS_W), .B_W(SUM_MAG_W)) u_mul_feed (
      .clock   (clock),
      .reset   (reset),
      .start   (feed_start),
      .mul_a   (gcos_prod),
      .mul_b   (force_sum_ff[SUM_MAG_W-1:0]),
      .product (feed_prod),
      .stat    (feed_stat)
   );

   // Phase rate: feedback term rounded half up, signed by cos, saturated.
   always_comb begin
      feed_rnd = {1'b0, feed_prod} + (FEED_W + 1)'(Q15_HALF);
      term_big = |feed_rnd[FEED_W:31];
      if (trig.cos_neg) begin
         rate_sum = {{2{phase_step_ff[15]}}, phase_step_ff} + {2'b00, feed_rnd[30:15]};
      end else begin
         rate_sum = {{2{phase_step_ff[15]}}, phase_step_ff} - {2'b00, feed_rnd[30:15]};
      end
      priority if (term_big) begin
         rate_val = trig.cos_neg ? 16'h7FFF : 16'h8000;
      end else if (rate_sum[17:15] != {3{rate_sum[17]}}) begin
         rate_val = rate_sum[17] ? 16'h8000 : 16'h7FFF;
      end else begin
         rate_val = rate_sum[15:0];
      end
   end

   // Rate moved to the phase's binary point; a right shift floors.
   assign rate_aligned   = $signed({rate_val, 24'd0}) >>> RATE_SHIFT;
   assign start_wide     = {csr_pwdata[15:0], 24'd0};
   assign phase_out_wide = {phase_ff, 16'd0};

   // Add of the force sample to the sum (or to zero on clear), one bit wider for the overflow check.
   always_comb begin
      force_base = (req_mode == MODE_CLEAR_ADD) ? '0 : force_sum_ff;
      force_add  = {force_base[SUM_W-1], force_base}
                 + {{(SUM_W + 1 - FORCE_W){req_reaction_force[FORCE_W-1]}},
                    req_reaction_force};
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_mode == MODE_TICK) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_MUL_TRIG;
         end
         ST_MUL_TRIG: begin
            if (gcos_stat.done) begin
               state_in = ST_MUL_FEED;
            end
         end
         ST_MUL_FEED: begin
            if (feed_stat.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      trig_start = 1'b0;
      feed_start = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:     req_stall  = 1'b0;
         ST_LOOKUP:   trig_start = 1'b1;
         ST_MUL_TRIG: feed_start = gcos_stat.done;
         ST_MUL_FEED: ;
         ST_FINISH:   out_load   = out_free;
         default: ;
      endcase
   end

   // Force sum: add on force beats, clamp at zero when a tick is taken.
   always_comb begin
      force_sum_in = force_sum_ff;
      if (req_take) begin
         unique case (mode_type'(req_mode))
            MODE_CLEAR_ADD, MODE_ADD: begin
               if (force_add[SUM_W] != force_add[SUM_W-1]) begin
                  force_sum_in = force_add[SUM_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               end else begin
                  force_sum_in = force_add[SUM_W-1:0];
               end
            end
            MODE_TICK: begin
               force_sum_in = force_sum_ff[SUM_W-1] ? '0 : force_sum_ff;
            end
            default: ;
         endcase
      end
   end

   // Phase: a start_phase write loads it, a finished tick advances it.
   always_comb begin
      phase_in = phase_ff;
      priority if (cfg_wr && csr_index_type'(cfg_idx) == CSR_START_PHASE) begin
         phase_in = start_wide[39 -: PHASE_BITS];
      end else if (out_load) begin
         phase_in = phase_ff + rate_aligned[PHASE_BITS-1:0];
      end else begin
         phase_in = phase_ff;
      end
   end

   // Result register: hold while stalled, load when a tick finishes.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_fore_in   = rsp_fore_ff;
      rsp_height_in = rsp_height_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_rate_in   = rsp_rate_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_fore_in   = round_q15(fore_prod, fore_amplitude_ff[15] ^ trig.cos_neg);
         rsp_height_in = round_q15(height_prod, height_amp[15] ^ trig.sin_neg);
         rsp_phase_in  = phase_out_wide[PHASE_BITS+15 -: 16];
         rsp_rate_in   = rate_val;
      end
   end

   // Control state and registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ST_IDLE;
         phase_ff            <= '0;
         force_sum_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
         phase_step_ff       <= '0;
         feedback_gain_ff    <= '0;
         swing_amplitude_ff  <= '0;
         stance_amplitude_ff <= '0;
         fore_amplitude_ff   <= '0;
         start_phase_ff      <= '0;
      end else begin
         state_ff            <= state_in;
         phase_ff            <= phase_in;
         force_sum_ff        <= force_sum_in;
         rsp_valid_ff        <= rsp_valid_in;
         phase_step_ff       <= phase_step_in;
         feedback_gain_ff    <= feedback_gain_in;
         swing_amplitude_ff  <= swing_amplitude_in;
         stance_amplitude_ff <= stance_amplitude_in;
         fore_amplitude_ff   <= fore_amplitude_in;
         start_phase_ff      <= start_phase_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_fore_ff   <= rsp_fore_in;
      rsp_height_ff <= rsp_height_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_rate_ff   <= rsp_rate_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fore_target   = rsp_fore_ff;
   assign rsp_height_target = rsp_height_ff;
   assign rsp_phase_now     = rsp_phase_ff;
   assign rsp_phase_rate    = rsp_rate_ff;

   // Neither the gain-cosine nor the feedback multiplier may still be running once the sequencer is back in idle.
   `TPO_ASSERT_IMP(a_idle_mul_quiet, state_ff == ST_IDLE, !(gcos_stat.busy || feed_stat.busy))
   // The three trig products finish together.
   `TPO_ASSERT_IMP(a_trig_done_aligned, gcos_stat.done, fore_stat.done && height_stat.done)
   // A tick works on a force sum already clamped at zero.
   `TPO_ASSERT_IMP(a_sum_clamped, state_ff == ST_MUL_TRIG, !force_sum_ff[SUM_W-1])
   // The phase holds while a tick is in flight, barring a register write.
   `TPO_ASSERT_NEXT(a_phase_held, (state_ff == ST_LOOKUP || state_ff == ST_MUL_TRIG || state_ff == ST_MUL_FEED) && !cfg_wr, $stable(phase_ff))
   // A finishing tick with a free result register delivers and returns to idle.
   `TPO_ASSERT_NEXT(a_finish_loads, state_ff == ST_FINISH && out_free, rsp_valid_ff && state_ff == ST_IDLE)

endmodule

// ===== tb/tb_tegotae_phase_oscillator_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Tegotae phase oscillator top level.
// Holds its own fixed-point model of the oscillator; needs only tpo_pkg and the RTL.
module tb_tegotae_phase_oscillator_top;
   import tpo_pkg::*;

   // Model sizes follow the defaults the block is built with.
   localparam int PHASE_W = TPO_PHASE_BITS;
   localparam int SINE_W  = TPO_SINE_TABLE_BITS;
   localparam int PH_UP   = (PHASE_W >= 16) ? PHASE_W - 16 : 0;
   localparam int PH_DOWN = (PHASE_W < 16) ? 16 - PHASE_W : 0;
   localparam int IX_DOWN = (PHASE_W >= SINE_W) ? PHASE_W - SINE_W : 0;
   localparam int IX_UP   = (PHASE_W < SINE_W) ? SINE_W - PHASE_W : 0;
   localparam logic [63:0] PHASE_MASK = (64'd1 << PHASE_W) - 64'd1;
   localparam logic [63:0] ONE_Q30    = 64'd1073741824;
   localparam logic [63:0] TURN_Q30   = 64'd6746518852;

   localparam int NUM_CSR         = 6;
   localparam logic [2:0] CSR_UNUSED  = 3'd7;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 24;
   localparam int HOLD_CYCLES     = 300;
   localparam int SAT_RUN         = 258;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int CYCLE_LIMIT     = 500000;

   // One result beat of a tick.
   typedef struct packed {
      logic signed [15:0] fore;
      logic signed [15:0] height;
      logic [15:0]        phase_now;
      logic signed [15:0] rate;
   } target_beat_t;

   // One row of the directed stimulus: an input beat or a register write.
   typedef struct packed {
      logic         is_csr;
      logic [2:0]   csr;
      logic [1:0]   mode;
      logic [23:0]  value;
      logic         typed;
      target_beat_t exp_beat;
   } dir_row_t;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_mode;
   logic [23:0]           req_reaction_force;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic signed [15:0]    rsp_fore_target;
   logic signed [15:0]    rsp_height_target;
   logic [15:0]           rsp_phase_now;
   logic signed [15:0]    rsp_phase_rate;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Model state and configuration.
   logic [15:0]  osc_cfg [NUM_CSR];
   logic [63:0]  osc_phase;
   longint       ground_sum;

   target_beat_t pending_targets[$];
   dir_row_t     directed_rows[$];
   int           mismatch_count;
   int           phase_items;
   bit           sender_steady;
   bit           hold_request;
   int           cycle_count;

   tegotae_phase_oscillator_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_reaction_force (req_reaction_force),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fore_target    (rsp_fore_target),
      .rsp_height_target  (rsp_height_target),
      .rsp_phase_now      (rsp_phase_now),
      .rsp_phase_rate     (rsp_phase_rate),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Q1.15 sine of table point idx: Taylor series to x^11 in Q30 on a folded quarter wave.
   function automatic int table_sine(input logic [63:0] idx);
      logic [63:0] quarter;
      logic [63:0] quad;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] acc;
      logic [63:0] s;
      logic [63:0] m;
      int          j;
      quarter = 64'd1 << (SINE_W - 2);
      idx     = idx & ((64'd1 << SINE_W) - 64'd1);
      quad    = idx >> (SINE_W - 2);
      r       = idx & (quarter - 64'd1);
      if (quad[0]) begin
         r = quarter - r;
      end
      x   = (r * TURN_Q30) >> SINE_W;
      x2  = (x * x) >> 30;
      acc = ONE_Q30;
      // Horner form, innermost term first: divide by (2j)(2j+1).
      for (j = 5; j >= 1; j--) begin
         acc = ONE_Q30 - ((x2 * acc) >> 30) / (64'(2 * j) * 64'(2 * j + 1));
      end
      s = (x * acc) >> 30;
      m = (s + 64'd16384) >> 15;
      if (m > 64'd32767) begin
         m = 64'd32767;
      end
      return (quad >= 64'd2) ? -int'(m) : int'(m);
   endfunction

   // Amplitude times Q1.15 trig, divided by 2^15 and rounded half away from zero.
   function automatic logic signed [15:0] amp_scale(input logic signed [15:0] amp,
                                                    input int trig);
      longint p;
      longint r;
      p = longint'(amp) * longint'(trig);
      r = ((p < 0 ? -p : p) + 64'sd16384) >>> 15;
      return 16'((p < 0) ? -r : r);
   endfunction

   // Applies one accepted input beat to the model; a tick yields a result beat.
   task automatic step_oscillator(input logic [1:0] mode, input logic signed [23:0] sample,
                                  output bit ticked, output target_beat_t beat);
      logic [63:0]        k;
      logic [63:0]        n;
      logic [63:0]        mag;
      logic [63:0]        term;
      longint             total;
      longint             rate;
      int                 cos_q;
      int                 sin_q;
      logic signed [15:0] amp_h;
      ticked = 1'b0;
      beat   = '0;
      if (mode == MODE_CLEAR_ADD || mode == MODE_ADD) begin
         // Force sample: clear or accumulate, saturating at 32 bits signed.
         total = (mode == MODE_CLEAR_ADD) ? longint'(sample) : ground_sum + longint'(sample);
         if (total > 64'sd2147483647) begin
            total = 64'sd2147483647;
         end
         if (total < -64'sd2147483648) begin
            total = -64'sd2147483648;
         end
         ground_sum = total;
      end else if (mode == MODE_TICK) begin
         k     = (osc_phase >> IX_DOWN) << IX_UP;
         cos_q = table_sine(k + (64'd1 << (SINE_W - 2)));
         sin_q = table_sine(k);
         // A negative sum is clamped and stored back.
         if (ground_sum < 0) begin
            ground_sum = 0;
         end
         n    = 64'(ground_sum);
         mag  = 64'((cos_q < 0) ? -cos_q : cos_q);
         term = (64'(osc_cfg[CSR_FEEDBACK_GAIN]) * n * mag + 64'd16384) >> 15;
         if (term > (64'd1 << 40)) begin
            term = 64'd1 << 40;
         end
         rate = longint'(signed'(osc_cfg[CSR_PHASE_STEP]));
         rate = (cos_q < 0) ? rate + longint'(term) : rate - longint'(term);
         if (rate > 32767) begin
            rate = 32767;
         end
         if (rate < -32768) begin
            rate = -32768;
         end
         amp_h = osc_phase[PHASE_W-1] ? osc_cfg[CSR_STANCE_AMPLITUDE]
                                      : osc_cfg[CSR_SWING_AMPLITUDE];
         beat.fore      = amp_scale(osc_cfg[CSR_FORE_AMPLITUDE], cos_q);
         beat.height    = amp_scale(amp_h, sin_q);
         beat.phase_now = 16'((osc_phase >> PH_UP) << PH_DOWN);
         beat.rate      = 16'(rate);
         // The phase wraps modulo one turn, also for negative rates.
         osc_phase = (osc_phase + 64'((rate <<< PH_UP) >>> PH_DOWN)) & PHASE_MASK;
         ticked    = 1'b1;
      end
   endtask

   task automatic report_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      $display("mismatch at %0t: %0s expected %0d got %0d", $realtime, what, want, got);
   endtask

   // Register write: setup phase, then access phase until pready.
   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx < NUM_CSR) begin
         osc_cfg[idx] = value;
         if (idx == CSR_START_PHASE) begin
            osc_phase = ((64'(value) << PH_UP) >> PH_DOWN) & PHASE_MASK;
         end
      end
      @(posedge clock);
   endtask

   function automatic int sender_gap();
      int pick;
      if (sender_steady) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         return 0;
      end else if (pick < 88) begin
         return $urandom_range(1, 3);
      end else if (pick < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Offers one input beat, holds it until accepted, then updates the model.
   task automatic send_item(input logic [1:0] mode, input logic [23:0] value,
                            input bit typed = 1'b0, input target_beat_t typed_beat = '0);
      int           gap;
      bit           ticked;
      target_beat_t beat;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_reaction_force <= value;
      do @(posedge clock); while (req_stall);
      step_oscillator(mode, value, ticked, beat);
      if (ticked) begin
         pending_targets.push_back(typed ? typed_beat : beat);
      end
      if (mode != MODE_UNUSED) begin
         phase_items++;
      end
   endtask

   // Lets every pending result drain, then gives the block time to go idle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_targets.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_force();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 9) begin
         return 24'($urandom_range(0, 128)) - 24'd64;
      end else if (pick < 14) begin
         return 24'($urandom_range(0, 8192)) - 24'd4096;
      end else if (pick < 18) begin
         return 24'($urandom());
      end else if (pick == 18) begin
         return 24'h7FFFFF;
      end
      return 24'h800000;
   endfunction

   function automatic dir_row_t item_row(input logic [1:0] mode, input logic [23:0] value);
      dir_row_t row;
      row       = '0;
      row.mode  = mode;
      row.value = value;
      return row;
   endfunction

   function automatic dir_row_t csr_row(input logic [2:0] idx, input logic [15:0] value);
      dir_row_t row;
      row        = '0;
      row.is_csr = 1'b1;
      row.csr    = idx;
      row.value  = 24'(value);
      return row;
   endfunction

   function automatic dir_row_t tick_row(input logic signed [15:0] fore,
                                         input logic signed [15:0] height,
                                         input logic [15:0] phase_now,
                                         input logic signed [15:0] rate);
      dir_row_t row;
      row                    = '0;
      row.mode               = MODE_TICK;
      row.typed              = 1'b1;
      row.exp_beat.fore      = fore;
      row.exp_beat.height    = height;
      row.exp_beat.phase_now = phase_now;
      row.exp_beat.rate      = rate;
      return row;
   endfunction

   // Result side: random stalls, free stretches, and one long hold on request.
   initial begin
      int n_go;
      int n_stall;
      int pick;
      rsp_stall <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n_go = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 5);
         rsp_stall <= 1'b0;
         repeat (n_go) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            n_stall = 0;
         end else if (pick < 85) begin
            n_stall = $urandom_range(1, 3);
         end else if (pick < 95) begin
            n_stall = $urandom_range(4, 12);
         end else begin
            n_stall = $urandom_range(20, 40);
         end
         if (n_stall > 0) begin
            rsp_stall <= 1'b1;
            repeat (n_stall) @(posedge clock);
         end
      end
   end

   // Each accepted result beat is checked against the oldest expectation.
   always @(posedge clock) begin
      target_beat_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_targets.size() == 0) begin
            report_mismatch("result beat with nothing pending, phase_now", -1, rsp_phase_now);
         end else begin
            want = pending_targets.pop_front();
            if (rsp_fore_target !== want.fore) begin
               report_mismatch("fore_target", want.fore, rsp_fore_target);
            end
            if (rsp_height_target !== want.height) begin
               report_mismatch("height_target", want.height, rsp_height_target);
            end
            if (rsp_phase_now !== want.phase_now) begin
               report_mismatch("phase_now", want.phase_now, rsp_phase_now);
            end
            if (rsp_phase_rate !== want.rate) begin
               report_mismatch("phase_rate", want.rate, rsp_phase_rate);
            end
         end
      end
   end

   // Run limit.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[tegotae_phase_oscillator_top] ERROR");
      $finish;
   end

   initial begin
      int          i;
      int          j;
      int          phase_no;
      int          pick;
      bit          paused;
      logic [15:0] value;
      bit          is_unsigned;

      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_mode           <= MODE_CLEAR_ADD;
      req_reaction_force <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      mismatch_count = 0;
      phase_items    = 0;
      sender_steady  = 1'b0;
      hold_request   = 1'b0;
      for (j = 0; j < NUM_CSR; j++) begin
         osc_cfg[j] = '0;
      end
      osc_phase  = '0;
      ground_sum = 0;

      // Directed rows. Typed expectations: reset state, quarter turn, full negative step.
      directed_rows.push_back(tick_row(16'sd0, 16'sd0, 16'd0, 16'sd0));
      directed_rows.push_back(item_row(MODE_UNUSED, 24'h7FFFFF));
      directed_rows.push_back(tick_row(16'sd0, 16'sd0, 16'd0, 16'sd0));
      directed_rows.push_back(csr_row(CSR_FORE_AMPLITUDE, 16'h7FFF));
      directed_rows.push_back(csr_row(CSR_SWING_AMPLITUDE, 16'h7FFF));
      directed_rows.push_back(csr_row(CSR_START_PHASE, 16'h4000));
      directed_rows.push_back(tick_row(16'sd0, 16'sd32766, 16'h4000, 16'sd0));
      directed_rows.push_back(csr_row(CSR_PHASE_STEP, 16'd1000));
      directed_rows.push_back(csr_row(CSR_FEEDBACK_GAIN, 16'd40000));
      directed_rows.push_back(csr_row(CSR_STANCE_AMPLITUDE, 16'h8000));
      directed_rows.push_back(csr_row(CSR_FORE_AMPLITUDE, 16'h8000));
      directed_rows.push_back(csr_row(CSR_START_PHASE, 16'h0000));
      // Negative sum is clamped to zero by the tick.
      directed_rows.push_back(item_row(MODE_CLEAR_ADD, 24'h800000));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));
      // Large positive sum drives the rate into negative saturation.
      directed_rows.push_back(item_row(MODE_CLEAR_ADD, 24'h000000));
      directed_rows.push_back(item_row(MODE_ADD, 24'h7FFFFF));
      directed_rows.push_back(item_row(MODE_ADD, 24'h7FFFFF));
      directed_rows.push_back(item_row(MODE_TICK, 24'hFFFFFF));
      // Second half turn with negative cosine: stance height, positive saturation.
      directed_rows.push_back(csr_row(CSR_START_PHASE, 16'hA000));
      directed_rows.push_back(item_row(MODE_CLEAR_ADD, 24'd300));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));
      // Full negative step wraps the phase below zero.
      directed_rows.push_back(csr_row(CSR_PHASE_STEP, 16'h8000));
      directed_rows.push_back(csr_row(CSR_FEEDBACK_GAIN, 16'd0));
      directed_rows.push_back(csr_row(CSR_START_PHASE, 16'h0000));
      directed_rows.push_back(tick_row(-16'sd32767, 16'sd0, 16'd0, -16'sd32768));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));
      // A write to an unmapped register must change nothing.
      directed_rows.push_back(csr_row(CSR_UNUSED, 16'hFFFF));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));
      // Small gain gives an unsaturated feedback term.
      directed_rows.push_back(csr_row(CSR_FEEDBACK_GAIN, 16'd3));
      directed_rows.push_back(item_row(MODE_CLEAR_ADD, 24'd1000));
      directed_rows.push_back(item_row(MODE_ADD, -24'sd250));
      directed_rows.push_back(item_row(MODE_TICK, 24'h000000));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].is_csr) begin
            wait_drained();
            csr_write(directed_rows[i].csr, directed_rows[i].value[15:0]);
         end else begin
            send_item(directed_rows[i].mode, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].exp_beat);
         end
      end

      // Random phases, each with its own register setting; the first two at the extremes.
      for (phase_no = 0; phase_no < NUM_PHASES; phase_no++) begin
         wait_drained();
         for (j = 0; j < NUM_CSR; j++) begin
            is_unsigned = (j == CSR_FEEDBACK_GAIN) || (j == CSR_START_PHASE);
            if (phase_no == 0) begin
               value = is_unsigned ? 16'hFFFF : 16'h7FFF;
            end else if (phase_no == 1) begin
               value = is_unsigned ? 16'h0000 : 16'h8000;
            end else if (j == CSR_FEEDBACK_GAIN && $urandom_range(0, 9) < 7) begin
               value = 16'($urandom_range(0, 300));
            end else begin
               value = 16'($urandom());
            end
            csr_write(3'(j), value);
         end
         if ($urandom_range(0, 2) == 0) begin
            csr_write(CSR_UNUSED, 16'($urandom()));
         end
         sender_steady = (phase_no == 3) || (phase_no == 4);
         // Long result hold while the sender keeps offering beats.
         if (phase_no == 3) begin
            hold_request = 1'b1;
         end
         // Sum saturation: enough full-scale adds to pass the 32-bit limit.
         if (phase_no == 2) begin
            send_item(MODE_CLEAR_ADD, 24'h7FFFFF);
            repeat (SAT_RUN) send_item(MODE_ADD, 24'h7FFFFF);
            send_item(MODE_TICK, rand_force());
         end
         phase_items = 0;
         paused      = 1'b0;
         while (phase_items < ITEMS_PER_PHASE) begin
            if (phase_no == 5 && !paused && phase_items >= ITEMS_PER_PHASE / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               // Well-formed: clear, a few adds, one or more ticks.
               send_item(MODE_CLEAR_ADD, rand_force());
               repeat ($urandom_range(0, 3)) send_item(MODE_ADD, rand_force());
               repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : 1)
                  send_item(MODE_TICK, rand_force());
            end else if (pick < 85) begin
               send_item(MODE_TICK, rand_force());
            end else if (pick < 93) begin
               send_item(MODE_ADD, rand_force());
            end else begin
               send_item(MODE_UNUSED, rand_force());
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("[tegotae_phase_oscillator_top] OK");
      end else begin
         $display("[tegotae_phase_oscillator_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/tpo_pkg.sv
sv/tpo_trig.sv
sv/tpo_digit_mul.sv
sv/tegotae_phase_oscillator_top.sv
tb/tb_tegotae_phase_oscillator_top.sv
